// ===== design/bounding_sphere_merge_macros.svh =====
// Assertion macros shared by the sphere merge RTL.
`ifndef BOUNDING_SPHERE_MERGE_MACROS_SVH
`define BOUNDING_SPHERE_MERGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sphere merge: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sphere merge: next-cycle check failed");

`endif

// ===== design/bsm_pkg.sv =====
// Shared constants and types of the sphere merge block.
`timescale 1ns / 1ps
`default_nettype none
package bsm_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int CFG_WIDTH = 16;
   localparam int INFLATE_SHIFT = 26;
   localparam logic [CFG_WIDTH-1:0] INFLATE_RESET = 16'd6711;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_DIST = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INFLATE = 4'd1;

   typedef enum logic [1:0] {
      CASE_SECOND_HOLDS = 2'd0,
      CASE_FIRST_HOLDS = 2'd1,
      CASE_MERGED = 2'd2,
      CASE_COINCIDENT = 2'd3
   } merge_case_type;

endpackage
`default_nettype wire

// ===== design/bsm_if.sv =====
// Valid/ready channel interfaces of the sphere merge block.
`timescale 1ns / 1ps
`default_nettype none
interface bsm_req_if #(parameter int W = bsm_pkg::COORD_WIDTH_DEFAULT);
   logic valid;
   logic ready;
   logic signed [W-1:0] first_center_x;
   logic signed [W-1:0] first_center_y;
   logic signed [W-1:0] first_center_z;
   logic [W-2:0] first_radius;
   logic signed [W-1:0] second_center_x;
   logic signed [W-1:0] second_center_y;
   logic signed [W-1:0] second_center_z;
   logic [W-2:0] second_radius;
   modport source (output valid, first_center_x, first_center_y, first_center_z,
      first_radius, second_center_x, second_center_y, second_center_z,
      second_radius, input ready);
   modport sink (input valid, first_center_x, first_center_y, first_center_z,
      first_radius, second_center_x, second_center_y, second_center_z,
      second_radius, output ready);
endinterface

interface bsm_rsp_if #(parameter int W = bsm_pkg::COORD_WIDTH_DEFAULT);
   logic valid;
   logic ready;
   logic signed [W-1:0] merged_center_x;
   logic signed [W-1:0] merged_center_y;
   logic signed [W-1:0] merged_center_z;
   logic [W-2:0] merged_radius;
   logic [1:0] merge_case;
   logic overflow;
   modport source (output valid, merged_center_x, merged_center_y, merged_center_z,
      merged_radius, merge_case, overflow, input ready);
   modport sink (input valid, merged_center_x, merged_center_y, merged_center_z,
      merged_radius, merge_case, overflow, output ready);
endinterface

interface bsm_csr_if;
   import bsm_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/bsm_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module bsm_divider #(
   parameter int N = bsm_pkg::COORD_WIDTH_DEFAULT + 1
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*N-1:0] num,
   input  logic [N-1:0]   den,
   output logic [N-1:0]   quo
);

   logic [N-1:0] rem_ff [N];
   logic [N-1:0] low_ff [N];
   logic [N-1:0] q_ff   [N];
   logic [N-1:0] den_ff [N];

   // The quotient fits N bits, so the upper half of the numerator is already below den.
   for (genvar j = 0; j < N; j++) begin : g_step
      logic [N-1:0] rem_prev;
      logic [N-1:0] low_prev;
      logic [N-1:0] q_prev;
      logic [N-1:0] den_prev;
      logic [N:0]   trial;
      logic [N:0]   diff;
      logic         take;
      logic [N-1:0] rem_in;
      logic [N-1:0] q_in;

      if (j == 0) begin : g_first
         assign rem_prev = num[2*N-1:N];
         assign low_prev = num[N-1:0];
         assign q_prev = '0;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign low_prev = low_ff[j-1];
         assign q_prev = q_ff[j-1];
         assign den_prev = den_ff[j-1];
      end

      always_comb begin
         trial = {rem_prev, low_prev[N-1]};
         diff = trial - {1'b0, den_prev};
         take = trial >= {1'b0, den_prev};
         rem_in = take ? diff[N-1:0] : trial[N-1:0];
         q_in = {q_prev[N-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            low_ff[j] <= {low_prev[N-2:0], 1'b0};
            q_ff[j] <= q_in;
            den_ff[j] <= den_prev;
         end
      end
   end

   assign quo = q_ff[N-1];

endmodule
`default_nettype wire

// ===== design/bounding_sphere_merge.sv =====
// Top level of the pipelined enclosing-sphere merge of two spheres.
`timescale 1ns / 1ps
`default_nettype none
`include "bounding_sphere_merge_macros.svh"

// Takes one pair of spheres per word and returns the smallest sphere enclosing both, one
// result word per input word. The pipeline accepts a new word in every cycle unless stalled, and
// holds one item per stage; most of its depth comes from the square root
// (COORD_WIDTH+1 stages, one root bit each) and the three parallel dividers for the center
// offset (COORD_WIDTH+1 stages, one quotient bit each). When the result register holds a word
// that has not been taken, the whole pipeline holds and req_ch.ready is low; otherwise the
// result register is refilled in the same cycle it is read. Containment is decided exactly
// on squared integers; the merged radius is floor((d+r0+r1)/2) with d = floor(sqrt(|c1-c0|^2)),
// and every radius is then grown by radius*inflate_numerator/2^26 with saturation. The two
// configuration registers may be written at any time the block is idle; csr_ch is always ready.
module bounding_sphere_merge #(
   parameter int COORD_WIDTH = bsm_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS = bsm_pkg::FRAC_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   bsm_req_if.sink     req_ch,
   bsm_rsp_if.source   rsp_ch,
   bsm_csr_if.sink     csr_ch
);
   import bsm_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int N = W + 1;
   localparam int PW = N + CFG_WIDTH;
   localparam logic [CFG_WIDTH-1:0] MIN_DIST_RESET =
      CFG_WIDTH'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [N:0] RAD_MAX = (N+1)'({(W-1){1'b1}});

   typedef struct packed {
      logic [2:0][W-1:0] base;
      logic [2:0]        dxneg;
      logic [2:0][N-1:0] dxmag;
      logic [W-2:0]      r0;
      logic [W-1:0]      rsum;
      logic [W-2:0]      rmax;
      logic              cont;
      logic              second;
   } root_carry_type;

   typedef struct packed {
      logic [2:0][W-1:0] base;
      logic [2:0]        dxneg;
      logic [N-1:0]      rad;
      logic [PW-1:0]     infl_prod;
      merge_case_type    mcase;
   } div_carry_type;

   // Configuration registers.
   logic [CFG_WIDTH-1:0] min_dist_ff;
   logic [CFG_WIDTH-1:0] infl_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= MIN_DIST_RESET;
         infl_ff <= INFLATE_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_MIN_DIST: min_dist_ff <= csr_ch.data[CFG_WIDTH-1:0];
            CSR_INFLATE: infl_ff <= csr_ch.data[CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves whenever the result register is free or being read.
   logic out_v_ff;
   logic en;
   assign en = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // Stage A: center differences, their magnitudes and radius relations.
   logic [2:0][W-1:0] c0_w;
   logic [2:0][W-1:0] c1_w;
   logic [2:0][N-1:0] dx_w;
   logic [2:0][N-1:0] dxmag_in;

   assign c0_w = {req_ch.first_center_z, req_ch.first_center_y, req_ch.first_center_x};
   assign c1_w = {req_ch.second_center_z, req_ch.second_center_y, req_ch.second_center_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dx_w[i] = {c1_w[i][W-1], c1_w[i]} - {c0_w[i][W-1], c0_w[i]};
         dxmag_in[i] = dx_w[i][N-1] ? -dx_w[i] : dx_w[i];
      end
   end

   logic              va_ff;
   logic [2:0][W-1:0] c0_a_ff;
   logic [2:0][W-1:0] c1_a_ff;
   logic [2:0]        dxneg_a_ff;
   logic [2:0][N-1:0] dxmag_a_ff;
   logic [W-2:0]      dr_a_ff;
   logic [W-2:0]      r0_a_ff;
   logic [W-2:0]      rmax_a_ff;
   logic [W-1:0]      rsum_a_ff;
   logic              second_a_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c0_a_ff <= c0_w;
         c1_a_ff <= c1_w;
         dxneg_a_ff <= {dx_w[2][N-1], dx_w[1][N-1], dx_w[0][N-1]};
         dxmag_a_ff <= dxmag_in;
         second_a_ff <= req_ch.second_radius >= req_ch.first_radius;
         dr_a_ff <= (req_ch.second_radius >= req_ch.first_radius) ?
            req_ch.second_radius - req_ch.first_radius :
            req_ch.first_radius - req_ch.second_radius;
         rmax_a_ff <= (req_ch.second_radius >= req_ch.first_radius) ?
            req_ch.second_radius : req_ch.first_radius;
         r0_a_ff <= req_ch.first_radius;
         rsum_a_ff <= {1'b0, req_ch.first_radius} + {1'b0, req_ch.second_radius};
      end
   end

   // Stage B: squares of the axis distances and of the radius difference.
   logic                  vb_ff;
   logic [2:0][2*N-1:0]   sq_b_ff;
   logic [2*W-3:0]        drsq_b_ff;
   logic [2:0][W-1:0]     c0_b_ff;
   logic [2:0][W-1:0]     c1_b_ff;
   logic [2:0]            dxneg_b_ff;
   logic [2:0][N-1:0]     dxmag_b_ff;
   logic [W-2:0]          r0_b_ff;
   logic [W-2:0]          rmax_b_ff;
   logic [W-1:0]          rsum_b_ff;
   logic                  second_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_b_ff[i] <= dxmag_a_ff[i] * dxmag_a_ff[i];
         end
         drsq_b_ff <= dr_a_ff * dr_a_ff;
         c0_b_ff <= c0_a_ff;
         c1_b_ff <= c1_a_ff;
         dxneg_b_ff <= dxneg_a_ff;
         dxmag_b_ff <= dxmag_a_ff;
         r0_b_ff <= r0_a_ff;
         rmax_b_ff <= rmax_a_ff;
         rsum_b_ff <= rsum_a_ff;
         second_b_ff <= second_a_ff;
      end
   end

   // Stage C: squared center distance and the exact containment test.
   logic [2*N-1:0] sq_in;
   logic           cont_in;
   root_carry_type rc_in;

   always_comb begin
      sq_in = sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
      cont_in = (2*N)'(drsq_b_ff) >= sq_in;
      rc_in.base = (cont_in && second_b_ff) ? c1_b_ff : c0_b_ff;
      rc_in.dxneg = dxneg_b_ff;
      rc_in.dxmag = dxmag_b_ff;
      rc_in.r0 = r0_b_ff;
      rc_in.rsum = rsum_b_ff;
      rc_in.rmax = rmax_b_ff;
      rc_in.cont = cont_in;
      rc_in.second = second_b_ff;
   end

   logic           vc_ff;
   logic [2*N-1:0] sq_c_ff;
   root_carry_type rc_c_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_c_ff <= sq_in;
         rc_c_ff <= rc_in;
      end
   end

   // Square root: one result bit per stage from two radicand bits.
   logic [N-1:0]   sv_ff;
   logic [N+1:0]   rem_ff  [N];
   logic [N-1:0]   root_ff [N];
   logic [2*N-1:0] xs_ff   [N];
   root_carry_type rcs_ff  [N];

   for (genvar j = 0; j < N; j++) begin : g_root
      logic           v_prev;
      logic [N+1:0]   rem_prev;
      logic [N-1:0]   root_prev;
      logic [2*N-1:0] xs_prev;
      root_carry_type c_prev;
      logic [N+1:0]   part;
      logic [N+1:0]   trial;
      logic [N+1:0]   rem_in;
      logic [N-1:0]   root_in;

      if (j == 0) begin : g_first
         assign v_prev = vc_ff;
         assign rem_prev = '0;
         assign root_prev = '0;
         assign xs_prev = sq_c_ff;
         assign c_prev = rc_c_ff;
      end else begin : g_next
         assign v_prev = sv_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign xs_prev = xs_ff[j-1];
         assign c_prev = rcs_ff[j-1];
      end

      always_comb begin
         part = {rem_prev[N-1:0], xs_prev[2*N-1:2*N-2]};
         trial = {root_prev, 2'b01};
         if (part >= trial) begin
            rem_in = part - trial;
            root_in = {root_prev[N-2:0], 1'b1};
         end else begin
            rem_in = part;
            root_in = {root_prev[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else if (en) begin
            sv_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            root_ff[j] <= root_in;
            xs_ff[j] <= {xs_prev[2*N-3:0], 2'b00};
            rcs_ff[j] <= c_prev;
         end
      end
   end

   // Stage D: merged radius, center step length and the case decision.
   root_carry_type rd_w;
   logic [N-1:0]   dist_w;
   logic [N:0]     radsum_w;
   logic [N-1:0]   rad_in;
   logic [N-1:0]   k_in;
   merge_case_type mcase_in;

   assign rd_w = rcs_ff[N-1];
   assign dist_w = root_ff[N-1];

   always_comb begin
      radsum_w = {1'b0, dist_w} + (N+1)'(rd_w.rsum);
      rad_in = rd_w.cont ? N'(rd_w.rmax) : radsum_w[N:1];
      k_in = (rad_in >= N'(rd_w.r0)) ? rad_in - N'(rd_w.r0) : '0;
      if (rd_w.cont) begin
         mcase_in = rd_w.second ? CASE_SECOND_HOLDS : CASE_FIRST_HOLDS;
      end else if (dist_w > N'(min_dist_ff)) begin
         mcase_in = CASE_MERGED;
      end else begin
         mcase_in = CASE_COINCIDENT;
      end
   end

   logic              vd_ff;
   logic [2:0][W-1:0] base_d_ff;
   logic [2:0]        dxneg_d_ff;
   logic [2:0][N-1:0] dxmag_d_ff;
   logic [N-1:0]      rad_d_ff;
   logic [N-1:0]      k_d_ff;
   logic [N-1:0]      dist_d_ff;
   merge_case_type    mcase_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         base_d_ff <= rd_w.base;
         dxneg_d_ff <= rd_w.dxneg;
         dxmag_d_ff <= rd_w.dxmag;
         rad_d_ff <= rad_in;
         k_d_ff <= k_in;
         dist_d_ff <= dist_w;
         mcase_d_ff <= mcase_in;
      end
   end

   // Stage E: offset numerators per axis and the inflation product.
   logic                vde_ff;
   logic [2:0][2*N-1:0] prod_e_ff;
   logic [N-1:0]        dist_e_ff;
   div_carry_type       dc_e_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_e_ff[i] <= dxmag_d_ff[i] * k_d_ff;
         end
         dist_e_ff <= dist_d_ff;
         dc_e_ff.base <= base_d_ff;
         dc_e_ff.dxneg <= dxneg_d_ff;
         dc_e_ff.rad <= rad_d_ff;
         dc_e_ff.infl_prod <= rad_d_ff * infl_ff;
         dc_e_ff.mcase <= mcase_d_ff;
      end
   end

   // Offset quotients; the item's other fields ride alongside in a matching chain.
   logic [2:0][N-1:0] quo_w;

   for (genvar i = 0; i < 3; i++) begin : g_div
      bsm_divider #(.N(N)) u_div (
         .clock (clock),
         .en    (en),
         .num   (prod_e_ff[i]),
         .den   (dist_e_ff),
         .quo   (quo_w[i])
      );
   end

   logic [N-1:0]  dv_ff;
   div_carry_type dc_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_carry
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (en) begin
            dv_ff[j] <= (j == 0) ? vde_ff : dv_ff[(j == 0) ? 0 : j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dc_ff[j] <= (j == 0) ? dc_e_ff : dc_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // Stage F: apply the signed offsets, inflate the radius, saturate into the result register.
   div_carry_type       df_w;
   logic [2:0][N+1:0]   cen_w;
   logic [2:0][W-1:0]   cen_in;
   logic [2:0]          cen_ovf;
   logic [N:0]          radi_w;
   logic [W-2:0]        rad_out_in;
   logic                ovf_in;

   assign df_w = dc_ff[N-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [N+1:0] basex;
         logic [N+1:0] offv;
         basex = {{3{df_w.base[i][W-1]}}, df_w.base[i]};
         offv = (df_w.mcase == CASE_MERGED) ? {2'b00, quo_w[i]} : '0;
         cen_w[i] = df_w.dxneg[i] ? basex - offv : basex + offv;
         cen_ovf[i] = !((&cen_w[i][N+1:W-1]) || !(|cen_w[i][N+1:W-1]));
         cen_in[i] = cen_ovf[i] ? {cen_w[i][N+1], {(W-1){!cen_w[i][N+1]}}} :
            cen_w[i][W-1:0];
      end
      radi_w = {1'b0, df_w.rad} + (N+1)'(df_w.infl_prod[PW-1:INFLATE_SHIFT]);
      rad_out_in = (radi_w > RAD_MAX) ? RAD_MAX[W-2:0] : radi_w[W-2:0];
      ovf_in = (radi_w > RAD_MAX) || (|cen_ovf);
   end

   logic [2:0][W-1:0] cen_out_ff;
   logic [W-2:0]      rad_out_ff;
   merge_case_type    mcase_out_ff;
   logic              ovf_out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cen_out_ff <= cen_in;
         rad_out_ff <= rad_out_in;
         mcase_out_ff <= df_w.mcase;
         ovf_out_ff <= ovf_in;
      end
   end

   // Valid bits of the fixed stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         vde_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_ch.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= sv_ff[N-1];
         vde_ff <= vd_ff;
         out_v_ff <= dv_ff[N-1];
      end
   end

   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.merged_center_x = cen_out_ff[0];
   assign rsp_ch.merged_center_y = cen_out_ff[1];
   assign rsp_ch.merged_center_z = cen_out_ff[2];
   assign rsp_ch.merged_radius = rad_out_ff;
   assign rsp_ch.merge_case = mcase_out_ff;
   assign rsp_ch.overflow = ovf_out_ff;

   // A held result must hold the whole pipeline, including the input side.
   `BSM_ASSERT_IMP(a_stall_blocks_input, clock, reset, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready)
   // An accepted word must occupy the first stage on the next edge.
   `BSM_ASSERT_NXT(a_accept_fills_stage, clock, reset, req_ch.valid && req_ch.ready, va_ff)
   // Centers stay between the two inputs, so only the radius can saturate.
   `BSM_ASSERT_IMP(a_overflow_is_radius, clock, reset, rsp_ch.valid && rsp_ch.overflow, &rsp_ch.merged_radius)

endmodule
`default_nettype wire

// ===== tb/bounding_sphere_merge_test.sv =====
// Self-checking testbench of the enclosing-sphere merge block.
`timescale 1ns / 1ps
`default_nettype none
module bounding_sphere_merge_test;
   import bsm_pkg::*;

   localparam int W = COORD_WIDTH_DEFAULT;
   localparam logic [W-2:0] RADIUS_MAX = {(W-1){1'b1}};
   localparam logic signed [W-1:0] COORD_HI = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] COORD_LO = {1'b1, {(W-1){1'b0}}};
   // No register lives at this index, so a write to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 4'd7;
   localparam int DRAIN_CYCLES = 2*W + 30;
   localparam int RANDOM_PER_PHASE = 90;
   localparam int DIRECTED_COUNT = 12;

   // One input word: the two spheres.
   typedef struct packed {
      logic signed [W-1:0] fx, fy, fz;
      logic [W-2:0] fr;
      logic signed [W-1:0] sx, sy, sz;
      logic [W-2:0] sr;
   } sphere_pair_type;

   // One result word: the enclosing sphere and its flags.
   typedef struct packed {
      logic signed [W-1:0] cx, cy, cz;
      logic [W-2:0] r;
      merge_case_type mcase;
      logic ovf;
   } merged_sphere_type;

   // A directed row carries a typed-in answer only when it is obvious.
   typedef struct {
      sphere_pair_type pair;
      bit has_answer;
      merged_sphere_type answer;
   } directed_row_type;

   logic clock;
   logic reset;

   bsm_req_if req_ch();
   bsm_rsp_if rsp_ch();
   bsm_csr_if csr_ch();

   bounding_sphere_merge uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Local copy of the two configuration registers.
   logic [CFG_WIDTH-1:0] min_dist_reg;
   logic [CFG_WIDTH-1:0] inflate_reg;

   merged_sphere_type pending_merges[$];
   directed_row_type directed_rows[DIRECTED_COUNT];
   int errors = 0;
   int words_sent = 0;
   int words_received = 0;
   int contain_count = 0;
   int merge_count = 0;
   int coincident_count = 0;
   int overflow_count = 0;
   bit long_hold_done = 0;

   // The clock runs free from time zero.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety net: a hung handshake ends the run here.
   initial begin
      #20ms;
      $display("Timeout at %0t", $time);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Computes the smallest enclosing sphere, inflated and saturated, using
   // wide integer arithmetic so that nothing wraps.
   function automatic merged_sphere_type merge_spheres(sphere_pair_type p);
      logic signed [63:0] c0[3], c1[3], dx[3], cen[3];
      logic [127:0] dist_sq, dr_sq, cand_sq, scaled;
      logic [63:0] r0, r1, dr, root_len, cand, rad, shift, q, grow;
      merged_sphere_type res;
      bit second;
      res.ovf = 1'b0;
      c0[0] = {{32{p.fx[W-1]}}, p.fx};
      c0[1] = {{32{p.fy[W-1]}}, p.fy};
      c0[2] = {{32{p.fz[W-1]}}, p.fz};
      c1[0] = {{32{p.sx[W-1]}}, p.sx};
      c1[1] = {{32{p.sy[W-1]}}, p.sy};
      c1[2] = {{32{p.sz[W-1]}}, p.sz};
      r0 = {33'd0, p.fr};
      r1 = {33'd0, p.sr};
      dist_sq = '0;
      for (int i = 0; i < 3; i++) begin
         dx[i] = c1[i] - c0[i];
         dist_sq += {64'd0, magnitude(dx[i])} * {64'd0, magnitude(dx[i])};
      end
      dr = r1 >= r0 ? r1 - r0 : r0 - r1;
      dr_sq = {64'd0, dr} * {64'd0, dr};
      if (dr_sq >= dist_sq) begin
         // One sphere holds the other; on a tie the second one wins.
         second = r1 >= r0;
         for (int i = 0; i < 3; i++) cen[i] = second ? c1[i] : c0[i];
         rad = second ? r1 : r0;
         res.mcase = second ? CASE_SECOND_HOLDS : CASE_FIRST_HOLDS;
      end else begin
         root_len = '0;
         for (int b = 63; b >= 0; b--) begin
            cand = root_len | (64'd1 << b);
            cand_sq = {64'd0, cand} * {64'd0, cand};
            if (dist_sq >= cand_sq) root_len = cand;
         end
         rad = (root_len + r0 + r1) >> 1;
         shift = rad >= r0 ? rad - r0 : 64'd0;
         if (root_len > {48'd0, min_dist_reg}) begin
            for (int i = 0; i < 3; i++) begin
               scaled = ({64'd0, magnitude(dx[i])} * {64'd0, shift}) / {64'd0, root_len};
               q = scaled[63:0];
               cen[i] = dx[i] < 0 ? c0[i] - $signed(q) : c0[i] + $signed(q);
            end
            res.mcase = CASE_MERGED;
         end else begin
            for (int i = 0; i < 3; i++) cen[i] = c0[i];
            res.mcase = CASE_COINCIDENT;
         end
      end
      scaled = {64'd0, rad} * {112'd0, inflate_reg};
      grow = scaled[INFLATE_SHIFT +: 64];
      rad = rad + grow;
      if (rad > {33'd0, RADIUS_MAX}) begin
         rad = {33'd0, RADIUS_MAX};
         res.ovf = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         if (cen[i] > 64'(COORD_HI)) begin
            cen[i] = 64'(COORD_HI);
            res.ovf = 1'b1;
         end
         if (cen[i] < 64'(COORD_LO)) begin
            cen[i] = 64'(COORD_LO);
            res.ovf = 1'b1;
         end
      end
      res.cx = cen[0][W-1:0];
      res.cy = cen[1][W-1:0];
      res.cz = cen[2][W-1:0];
      res.r = rad[W-2:0];
      return res;
   endfunction

   // Gap length: mostly none, often a few cycles, now and then a long pause.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return COORD_HI;
         1: return COORD_LO;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Random sphere pairs of several shapes: wide random pairs, nearby pairs
   // that merge, one sphere nested in the other, nearly coincident centers
   // and field extremes.
   function automatic sphere_pair_type random_pair();
      sphere_pair_type p;
      int shape;
      shape = $urandom_range(0, 9);
      p.fx = $urandom;
      p.fy = $urandom;
      p.fz = $urandom;
      p.fr = (W-1)'($urandom);
      p.sx = $urandom;
      p.sy = $urandom;
      p.sz = $urandom;
      p.sr = (W-1)'($urandom);
      if (shape >= 3 && shape <= 5) begin
         p.sx = p.fx + $signed($urandom_range(0, 2**21) - 2**20);
         p.sy = p.fy + $signed($urandom_range(0, 2**21) - 2**20);
         p.sz = p.fz + $signed($urandom_range(0, 2**21) - 2**20);
         p.fr = (W-1)'($urandom_range(0, 2**20));
         p.sr = (W-1)'($urandom_range(0, 2**20));
      end else if (shape == 6 || shape == 7) begin
         p.sx = p.fx + $signed($urandom_range(0, 2**13) - 2**12);
         p.sy = p.fy + $signed($urandom_range(0, 2**13) - 2**12);
         p.sz = p.fz + $signed($urandom_range(0, 2**13) - 2**12);
         if (shape == 6) p.sr = (W-1)'($urandom_range(0, 2**12));
         else p.fr = (W-1)'($urandom_range(0, 2**12));
      end else if (shape == 8) begin
         p.sx = p.fx + $signed($urandom_range(0, 160) - 80);
         p.sy = p.fy + $signed($urandom_range(0, 160) - 80);
         p.sz = p.fz + $signed($urandom_range(0, 160) - 80);
         p.fr = (W-1)'($urandom_range(0, 40));
         p.sr = (W-1)'($urandom_range(0, 40));
      end else if (shape == 9) begin
         p.fx = pick_extreme();
         p.fy = pick_extreme();
         p.fz = pick_extreme();
         p.sx = pick_extreme();
         p.sy = pick_extreme();
         p.sz = pick_extreme();
         p.fr = $urandom_range(0, 1) ? RADIUS_MAX : p.fr;
         p.sr = $urandom_range(0, 1) ? '0 : p.sr;
      end
      return p;
   endfunction

   // Offers one word, waits for it to be taken and records the answer that
   // the result side must produce for it.
   task automatic send_pair(sphere_pair_type p, bit has_answer, merged_sphere_type answer);
      repeat (idle_cycles()) @(negedge clock);
      req_ch.first_center_x = p.fx;
      req_ch.first_center_y = p.fy;
      req_ch.first_center_z = p.fz;
      req_ch.first_radius = p.fr;
      req_ch.second_center_x = p.sx;
      req_ch.second_center_y = p.sy;
      req_ch.second_center_z = p.sz;
      req_ch.second_radius = p.sr;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_merges.insert(pending_merges.size(), has_answer ? answer : merge_spheres(p));
      words_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Writes one configuration register and mirrors it in the local copy.
   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_ch.index = index;
      csr_ch.data = value;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      if (index == CSR_MIN_DIST) min_dist_reg = value[CFG_WIDTH-1:0];
      else if (index == CSR_INFLATE) inflate_reg = value[CFG_WIDTH-1:0];
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Waits until every expected word has come back and the pipe has drained.
   task automatic wait_idle();
      wait (pending_merges.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic report_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
         errors++;
      end
   endtask

   // The result side stalls at random. Once, after a few dozen words, it
   // holds off for a long stretch so that the pipeline fills and the input
   // side must stall.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!long_hold_done && words_received >= 60) begin
            rsp_ch.ready = 1'b0;
            repeat (300) @(negedge clock);
            long_hold_done = 1;
         end else if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_cycles();
         end
      end
   end

   // Checks each returned word against the oldest expected one.
   always @(posedge clock) begin
      merged_sphere_type expected;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_received++;
         if (pending_merges.size() == 0) begin
            $display("%0t: unexpected result word, center %0h %0h %0h radius %0h", $time,
               rsp_ch.merged_center_x, rsp_ch.merged_center_y, rsp_ch.merged_center_z,
               rsp_ch.merged_radius);
            errors++;
         end else begin
            expected = pending_merges.pop_front();
            report_field("merged_center_x", 64'(expected.cx), 64'(rsp_ch.merged_center_x));
            report_field("merged_center_y", 64'(expected.cy), 64'(rsp_ch.merged_center_y));
            report_field("merged_center_z", 64'(expected.cz), 64'(rsp_ch.merged_center_z));
            report_field("merged_radius", 64'(expected.r), 64'(rsp_ch.merged_radius));
            report_field("merge_case", 64'(expected.mcase), 64'(rsp_ch.merge_case));
            report_field("overflow", 64'(expected.ovf), 64'(rsp_ch.overflow));
            case (expected.mcase)
               CASE_MERGED: merge_count++;
               CASE_COINCIDENT: coincident_count++;
               default: contain_count++;
            endcase
            if (expected.ovf) overflow_count++;
         end
      end
   end

   // Main sequence: reset, the directed table, then five random phases, the first and
   // the last under the reset register setting.
   initial begin
      sphere_pair_type p;
      merged_sphere_type none;
      none = '0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.first_center_x = '0;
      req_ch.first_center_y = '0;
      req_ch.first_center_z = '0;
      req_ch.first_radius = '0;
      req_ch.second_center_x = '0;
      req_ch.second_center_y = '0;
      req_ch.second_center_z = '0;
      req_ch.second_radius = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_MIN_DIST;
      csr_ch.data = '0;
      min_dist_reg = 16'd66;
      inflate_reg = INFLATE_RESET;

      // Two equal spheres at the origin with zero radius: the second wins.
      directed_rows[0] = '{'0, 1, '{0, 0, 0, 0, CASE_SECOND_HOLDS, 1'b0}};
      // A first sphere of radius 10 around a zero-radius second sphere on its center.
      directed_rows[1] = '{'{5, 0, 0, 10, 5, 0, 0, 0}, 1,
                           '{5, 0, 0, 10, CASE_FIRST_HOLDS, 1'b0}};
      // Two largest spheres on one center: inflation saturates the radius.
      directed_rows[2] = '{'{0, 0, 0, RADIUS_MAX, 0, 0, 0, RADIUS_MAX}, 1,
                           '{0, 0, 0, RADIUS_MAX, CASE_SECOND_HOLDS, 1'b1}};
      // Opposite corners of the coordinate range, with zero radii and with the largest radii.
      directed_rows[3] = '{'{COORD_LO, COORD_LO, COORD_LO, 0,
                             COORD_HI, COORD_HI, COORD_HI, 0}, 0, none};
      directed_rows[4] = '{'{COORD_HI, COORD_LO, COORD_HI, RADIUS_MAX,
                             COORD_LO, COORD_HI, COORD_LO, RADIUS_MAX}, 0, none};
      // Centers one step apart: too close to move the center, or one inside the other.
      directed_rows[5] = '{'{100, 200, 300, 0, 101, 200, 300, 0}, 0, none};
      directed_rows[6] = '{'{-7, -7, -7, 3, -7, -7, -6, 2}, 0, none};
      // Ordinary merges in positive and negative directions.
      directed_rows[7] = '{'{0, 0, 0, 32'h10000, 32'h50000, 0, 0, 32'h20000}, 0, none};
      directed_rows[8] = '{'{32'h30000, -32'h40000, 32'h1000, 32'h8000,
                             -32'h30000, 32'h40000, -32'h1000, 32'h18000}, 0, none};
      // Containment by the second sphere; none with a large first radius or a near pair.
      directed_rows[9] = '{'{32'h1000, 0, 0, 32'h100, 0, 0, 0, 32'h100000}, 0, none};
      directed_rows[10] = '{'{COORD_HI, COORD_HI, COORD_HI, RADIUS_MAX,
                              0, 0, 0, 0}, 0, none};
      directed_rows[11] = '{'{-1, -1, -1, 1, 0, 0, 0, 0}, 0, none};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_pair(directed_rows[i].pair, directed_rows[i].has_answer,
                   directed_rows[i].answer);
      repeat (RANDOM_PER_PHASE) send_pair(random_pair(), 0, none);

      // Each phase below changes the registers once the block is idle.
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_register(CSR_MIN_DIST, 32'd0);
               write_register(CSR_INFLATE, 32'd0);
            end
            1: begin
               write_register(CSR_MIN_DIST, 32'hFFFF_FFFF);
               write_register(CSR_INFLATE, 32'hFFFF_FFFF);
               write_register(CSR_UNUSED, 32'd0);
            end
            2: begin
               write_register(CSR_MIN_DIST, $urandom);
               write_register(CSR_INFLATE, $urandom);
            end
            default: begin
               write_register(CSR_MIN_DIST, 32'd66);
               write_register(CSR_INFLATE, 32'(INFLATE_RESET));
            end
         endcase
         repeat (RANDOM_PER_PHASE) send_pair(random_pair(), 0, none);
      end

      wait_idle();
      $display("Sent %0d sphere pairs, checked %0d results under 5 register settings.",
         words_sent, words_received);
      $display("Containment %0d, merged %0d, coincident %0d, saturated %0d.",
         contain_count, merge_count, coincident_count, overflow_count);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/bsm_pkg.sv
design/bsm_if.sv
design/bsm_divider.sv
design/bounding_sphere_merge.sv
tb/bounding_sphere_merge_test.sv
